// ===== rtl/mpfb_pkg.sv =====
package mpfb_pkg;

   localparam logic [2:0] KIND_SET_PIXEL = 3'd0;
   localparam logic [2:0] KIND_GET_PIXEL = 3'd1;
   localparam logic [2:0] KIND_HLINE     = 3'd2;
   localparam logic [2:0] KIND_VLINE     = 3'd3;
   localparam logic [2:0] KIND_RAW_HLINE = 3'd4;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_CLIP  = 2'd2;

   localparam logic [6:0] RAW_LAST_OFFSET = 7'd63;

endpackage

// ===== rtl/mpfb_ram.sv =====
module mpfb_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mono_page_framebuffer_draw.sv =====
// Page-layout 1-bit framebuffer (byte index (y>>3)*WIDTH+x, top pixel in bit 0) with
// set/get pixel, horizontal, vertical and raw horizontal line operations. After reset
// the block sweeps the store to zero, one byte per cycle, over all WIDTH*ceil(HEIGHT/8)
// bytes, and stalls requests meanwhile. A transaction is then handled one at a time:
// rejected requests and empty vertical lines answer in the cycle after acceptance; any
// other request walks each pixel touched through a read state and a write state (a
// read-modify-write of its byte on the framebuffer RAM, with no write for get pixel).
// The response sits in an output register until taken.
module mono_page_framebuffer_draw #(
   parameter int WIDTH  = 128,
   parameter int HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic        req_color,
   input  logic [6:0]  req_x_start,
   input  logic [6:0]  req_x_end,
   input  logic [5:0]  req_y_start,
   input  logic [6:0]  req_y_end,
   input  logic [63:0] req_pixel_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_pixel,
   output logic [1:0]  rsp_status
);

   localparam int PAGES = (HEIGHT + 7) / 8;
   localparam int DEPTH = WIDTH * PAGES;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [8:0]    W9        = 9'(WIDTH);
   localparam logic [8:0]    H9        = 9'(HEIGHT);
   localparam logic [AW-1:0] CLR_LAST  = AW'(DEPTH - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD,
      ST_WR
   } state_type;

   state_type   state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [6:0]  x_ff, x_in;
   logic [6:0]  x_last_ff, x_last_in;
   logic [6:0]  y_ff, y_in;
   logic [6:0]  y_last_ff, y_last_in;
   logic        vert_ff, vert_in;
   logic        raw_ff, raw_in;
   logic        get_ff, get_in;
   logic        color_ff, color_in;
   logic [63:0] bits_ff, bits_in;
   logic [1:0]  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        pixel_ff, pixel_in;

   logic          req_accept;
   logic          rsp_free;
   logic [AW-1:0] pix_addr;
   logic [7:0]    rd_data;
   logic [7:0]    bit_mask;
   logic [7:0]    wr_data;
   logic          wr_en;
   logic          rd_en;
   logic [AW-1:0] wr_addr;
   logic          pix_color;
   logic          pix_last;
   logic          x_bad;
   logic          xe_bad;
   logic          y_bad;
   logic [6:0]    span;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !rsp_free;
   assign req_accept = req_valid && !req_stall;

   assign x_bad  = 9'(req_x_start) >= W9;
   assign xe_bad = 9'(req_x_end) >= W9;
   assign y_bad  = 9'(req_y_start) >= H9;
   assign span   = req_x_end - req_x_start;

   assign pix_addr  = AW'(32'(y_ff[6:3]) * 32'(WIDTH) + 32'(x_ff));
   assign bit_mask  = 8'(1) << y_ff[2:0];
   assign pix_color = raw_ff ? bits_ff[0] : color_ff;
   assign wr_data   = (state_ff == ST_CLEAR) ? 8'h00 :
                      (pix_color ? (rd_data | bit_mask) : (rd_data & ~bit_mask));
   assign wr_en     = (state_ff == ST_CLEAR) || ((state_ff == ST_WR) && !get_ff);
   assign wr_addr   = (state_ff == ST_CLEAR) ? clr_ff : pix_addr;
   assign rd_en     = (state_ff == ST_RD);
   assign pix_last  = vert_ff ? (y_ff == y_last_ff) : (x_ff == x_last_ff);

   mpfb_ram #(
      .DATA_W (8),
      .DEPTH  (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (pix_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      x_in         = x_ff;
      x_last_in    = x_last_ff;
      y_in         = y_ff;
      y_last_in    = y_last_ff;
      vert_in      = vert_ff;
      raw_in       = raw_ff;
      get_in       = get_ff;
      color_in     = color_ff;
      bits_in      = bits_ff;
      status_in    = status_ff;
      pixel_in     = pixel_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               x_in      = req_x_start;
               x_last_in = req_x_start;
               y_in      = 7'(req_y_start);
               y_last_in = 7'(req_y_start);
               vert_in   = 1'b0;
               raw_in    = 1'b0;
               get_in    = 1'b0;
               color_in  = req_color;
               bits_in   = req_pixel_bits;
               status_in = mpfb_pkg::STATUS_DONE;
               pixel_in  = 1'b0;
               case (req_kind)
                  mpfb_pkg::KIND_SET_PIXEL, mpfb_pkg::KIND_GET_PIXEL: begin
                     get_in = (req_kind == mpfb_pkg::KIND_GET_PIXEL);
                     if (x_bad || y_bad) begin
                        status_in    = mpfb_pkg::STATUS_RANGE;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_RD;
                     end
                  end
                  mpfb_pkg::KIND_HLINE, mpfb_pkg::KIND_RAW_HLINE: begin
                     raw_in    = (req_kind == mpfb_pkg::KIND_RAW_HLINE);
                     x_last_in = req_x_end;
                     if (x_bad || xe_bad || y_bad || (req_x_end < req_x_start)) begin
                        status_in    = mpfb_pkg::STATUS_RANGE;
                        rsp_valid_in = 1'b1;
                     end else begin
                        if (raw_in && span[6]) begin
                           x_last_in = req_x_start + mpfb_pkg::RAW_LAST_OFFSET;
                           status_in = mpfb_pkg::STATUS_CLIP;
                        end
                        state_in = ST_RD;
                     end
                  end
                  mpfb_pkg::KIND_VLINE: begin
                     vert_in   = 1'b1;
                     y_last_in = req_y_end - 7'd1;
                     if (x_bad || y_bad || (9'(req_y_end) > H9) ||
                         (req_y_end < 7'(req_y_start))) begin
                        status_in    = mpfb_pkg::STATUS_RANGE;
                        rsp_valid_in = 1'b1;
                     end else if (req_y_end == 7'(req_y_start)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_RD;
                     end
                  end
                  default: begin
                     status_in    = mpfb_pkg::STATUS_RANGE;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_RD: begin
            state_in = ST_WR;
         end
         ST_WR: begin
            if (get_ff) begin
               pixel_in = rd_data[y_ff[2:0]];
            end
            if (pix_last) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               x_in     = vert_ff ? x_ff : x_ff + 7'd1;
               y_in     = vert_ff ? y_ff + 7'd1 : y_ff;
               bits_in  = bits_ff >> 1;
               state_in = ST_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff      <= x_in;
      x_last_ff <= x_last_in;
      y_ff      <= y_in;
      y_last_ff <= y_last_in;
      vert_ff   <= vert_in;
      raw_ff    <= raw_in;
      get_ff    <= get_in;
      color_ff  <= color_in;
      bits_ff   <= bits_in;
      status_ff <= status_in;
      pixel_ff  <= pixel_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pixel  = pixel_ff;
   assign rsp_status = status_ff;

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff)
      else $error("response raised during clear pass");

   a_hline_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR && !vert_ff) |-> x_ff <= x_last_ff)
      else $error("horizontal walk passed its last column");

   a_vline_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR && vert_ff) |-> y_ff <= y_last_ff)
      else $error("vertical walk passed its last row");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD) |=> (state_ff == ST_WR) && $stable(x_ff) && $stable(y_ff))
      else $error("pixel address moved between read and write");

endmodule
